@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the pixel converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/rgb2yuv_pkg.sv @@
// Shared types, register codes and coefficients of the RGB to YUV 4:2:0 converter.
package rgb2yuv_pkg;

    // Default size limit of the source counters
    localparam int MAX_DIM_DEF = 4096;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH   = 4'd0,
        CFG_FRAME_HEIGHT  = 4'd1,
        CFG_PAD_WIDTH     = 4'd2,
        CFG_PAD_HEIGHT    = 4'd3,
        CFG_PIXEL_MODE    = 4'd4,
        CFG_INPUT_STRIDE  = 4'd5,
        CFG_LUMA_STRIDE   = 4'd6,
        CFG_CHROMA_STRIDE = 4'd7
    } t_cfg_idx;

    // pixel_mode bits
    localparam int MODE_ROTATE = 0;
    localparam int MODE_BGR    = 1;

    // Output address width
    localparam int ADDR_W = 24;

    typedef struct packed {
        logic [12:0] frame_width;
        logic [12:0] frame_height;
        logic [10:0] pad_width;
        logic [10:0] pad_height;
        logic [1:0]  pixel_mode;
        logic [12:0] input_stride;
        logic [12:0] luma_stride;
        logic [12:0] chroma_stride;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        frame_width:   13'd640,
        frame_height:  13'd480,
        pad_width:     11'd0,
        pad_height:    11'd0,
        pixel_mode:    2'd0,
        input_stride:  13'd640,
        luma_stride:   13'd640,
        chroma_stride: 13'd320
    };

    // BT.601 integer coefficients (magnitudes; signs are applied in the datapath)
    localparam int COEF_Y_R = 66;
    localparam int COEF_Y_G = 129;
    localparam int COEF_Y_B = 25;
    localparam int COEF_U_R = 38;
    localparam int COEF_U_G = 74;
    localparam int COEF_U_B = 112;
    localparam int COEF_V_R = 112;
    localparam int COEF_V_G = 94;
    localparam int COEF_V_B = 18;
    localparam int ROUND    = 128;
    localparam int OFS_Y    = 16;
    localparam int OFS_C    = 128;

endpackage

@@ hw/rtl/rgb_to_yuv420_pixel_converter_top.sv @@
// Top level of the RGB to YUV 4:2:0 pixel converter: counters, mapping and pipeline.
//
//  channel  direction  handshake                   payload
//  in       sink       i_in_valid / o_in_ready     i_first_byte .. i_frame_start
//  out      source     o_out_valid / i_out_ready   o_luma_value .. o_chroma_address
//  cfg      sink       i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
// One item per cycle while the output is not stalled; an active pixel's result passes through
// the position/mapping register, then the result register after the address multipliers.
// Inactive pixels only move the counters and give no result.
// Synchronous active-low reset clears counters and valids and loads the register defaults;
// data registers are not reset; no clearing pass.
// A stalled output holds its result; the mapping stage keeps taking items while it is free.
module rgb_to_yuv420_pixel_converter_top #(
    parameter int MAX_DIM = rgb2yuv_pkg::MAX_DIM_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [rgb2yuv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rgb2yuv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [7:0]                         i_first_byte,
    input  logic [7:0]                         i_second_byte,
    input  logic [7:0]                         i_third_byte,
    input  logic                               i_frame_start,
    // result items
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [7:0]                         o_luma_value,
    output logic [rgb2yuv_pkg::ADDR_W-1:0]     o_luma_address,
    output logic                               o_chroma_valid,
    output logic [7:0]                         o_cb_value,
    output logic [7:0]                         o_cr_value,
    output logic [rgb2yuv_pkg::ADDR_W-1:0]     o_chroma_address
);
    import rgb2yuv_pkg::*;

`include "assert_macros.svh"

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int XY_W  = (CNT_W + 1 > 14) ? CNT_W + 1 : 14;

    // Registers
    t_cfg             r_cfg;
    logic [CNT_W-1:0] r_col;
    logic [CNT_W-1:0] r_row;
    logic             r_past_end;
    logic             r_s1_valid;
    logic [XY_W-1:0]  r_s1_x;
    logic [XY_W-1:0]  r_s1_y;
    logic [7:0]       r_s1_red;
    logic [7:0]       r_s1_green;
    logic [7:0]       r_s1_blue;
    logic             r_out_valid;
    logic [7:0]       r_out_luma;
    logic [ADDR_W-1:0] r_out_luma_addr;
    logic             r_out_cvalid;
    logic [7:0]       r_out_cb;
    logic [7:0]       r_out_cr;
    logic [ADDR_W-1:0] r_out_chroma_addr;

    // Next values and combinational signals
    logic [CNT_W-1:0] n_col;
    logic [CNT_W-1:0] n_row;
    logic             n_past_end;
    logic [XY_W-1:0]  n_x;
    logic [XY_W-1:0]  n_y;
    logic [CNT_W-1:0] col_cur;
    logic [CNT_W-1:0] row_cur;
    logic             pe_cur;
    logic [XY_W-1:0]  wrap;
    logic [XY_W-1:0]  stride_ext;
    logic [XY_W-1:0]  col_inc;
    logic [XY_W-1:0]  row_inc;
    logic [XY_W-1:0]  span_w;
    logic [XY_W-1:0]  span_h;
    logic [XY_W-1:0]  cols;
    logic [XY_W-1:0]  rows;
    logic             rotate;
    logic             bgr;
    logic             active;
    logic             in_fire;
    logic             out_load;
    logic             s1_fire;

    logic [7:0]        c_luma;
    logic [ADDR_W-1:0] c_luma_addr;
    logic              c_cvalid;
    logic [7:0]        c_cb;
    logic [7:0]        c_cr;
    logic [ADDR_W-1:0] c_chroma_addr;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:   r_cfg.frame_width   <= i_cfg_data;
                CFG_FRAME_HEIGHT:  r_cfg.frame_height  <= i_cfg_data;
                CFG_PAD_WIDTH:     r_cfg.pad_width     <= i_cfg_data[10:0];
                CFG_PAD_HEIGHT:    r_cfg.pad_height    <= i_cfg_data[10:0];
                CFG_PIXEL_MODE:    r_cfg.pixel_mode    <= i_cfg_data[1:0];
                CFG_INPUT_STRIDE:  r_cfg.input_stride  <= i_cfg_data;
                CFG_LUMA_STRIDE:   r_cfg.luma_stride   <= i_cfg_data;
                CFG_CHROMA_STRIDE: r_cfg.chroma_stride <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: the mapping stage moves when the result register can load
    assign out_load   = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && out_load;
    assign o_in_ready = !r_s1_valid || out_load;
    assign in_fire    = i_in_valid && o_in_ready;

    assign rotate = r_cfg.pixel_mode[MODE_ROTATE];
    assign bgr    = r_cfg.pixel_mode[MODE_BGR];

    // Position, active test, mapping and counter advance
    always_comb begin
        col_cur = i_frame_start ? '0 : r_col;
        row_cur = i_frame_start ? '0 : r_row;
        pe_cur  = i_frame_start ? 1'b0 : r_past_end;

        stride_ext = XY_W'(r_cfg.input_stride);
        if (stride_ext == '0) begin
            wrap = XY_W'(1);
        end else if (stride_ext > XY_W'(MAX_DIM)) begin
            wrap = XY_W'(MAX_DIM);
        end else begin
            wrap = stride_ext;
        end

        span_w = (XY_W'(r_cfg.frame_width) >= XY_W'({r_cfg.pad_width, 1'b0}))
               ? XY_W'(r_cfg.frame_width) - XY_W'({r_cfg.pad_width, 1'b0}) : '0;
        span_h = (XY_W'(r_cfg.frame_height) >= XY_W'({r_cfg.pad_height, 1'b0}))
               ? XY_W'(r_cfg.frame_height) - XY_W'({r_cfg.pad_height, 1'b0}) : '0;
        cols = rotate ? span_h : span_w;
        rows = rotate ? span_w : span_h;

        active = !pe_cur && (XY_W'(col_cur) < cols) && (XY_W'(row_cur) < rows);

        if (rotate) begin
            n_x = XY_W'(row_cur) + XY_W'(r_cfg.pad_width);
            n_y = XY_W'(r_cfg.frame_height) - XY_W'(r_cfg.pad_height) - XY_W'(1)
                - XY_W'(col_cur);
        end else begin
            n_x = XY_W'(col_cur) + XY_W'(r_cfg.pad_width);
            n_y = XY_W'(row_cur) + XY_W'(r_cfg.pad_height);
        end

        col_inc    = XY_W'(col_cur) + XY_W'(1);
        row_inc    = XY_W'(row_cur) + XY_W'(1);
        n_col      = col_inc[CNT_W-1:0];
        n_row      = row_cur;
        n_past_end = pe_cur;
        if (col_inc >= wrap) begin
            n_col = '0;
            if (row_inc >= XY_W'(MAX_DIM)) begin
                n_past_end = 1'b1;
            end else begin
                n_row = row_inc[CNT_W-1:0];
            end
        end
    end

    // Counters and valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_past_end  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_col      <= n_col;
                r_row      <= n_row;
                r_past_end <= n_past_end;
            end
            if (in_fire) begin
                r_s1_valid <= active;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Mapped pixel register
    always_ff @(posedge i_clk) begin
        if (in_fire && active) begin
            r_s1_x     <= n_x;
            r_s1_y     <= n_y;
            r_s1_red   <= bgr ? i_third_byte : i_first_byte;
            r_s1_green <= i_second_byte;
            r_s1_blue  <= bgr ? i_first_byte : i_third_byte;
        end
    end

    rgb2yuv_calc #(
        .XY_W (XY_W)
    ) u_calc (
        .i_cfg            (r_cfg),
        .i_x              (r_s1_x),
        .i_y              (r_s1_y),
        .i_red            (r_s1_red),
        .i_green          (r_s1_green),
        .i_blue           (r_s1_blue),
        .o_luma_value     (c_luma),
        .o_luma_address   (c_luma_addr),
        .o_chroma_valid   (c_cvalid),
        .o_cb_value       (c_cb),
        .o_cr_value       (c_cr),
        .o_chroma_address (c_chroma_addr)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_luma        <= c_luma;
            r_out_luma_addr   <= c_luma_addr;
            r_out_cvalid      <= c_cvalid;
            r_out_cb          <= c_cb;
            r_out_cr          <= c_cr;
            r_out_chroma_addr <= c_chroma_addr;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_luma_value     = r_out_luma;
    assign o_luma_address   = r_out_luma_addr;
    assign o_chroma_valid   = r_out_cvalid;
    assign o_cb_value       = r_out_cb;
    assign o_cr_value       = r_out_cr;
    assign o_chroma_address = r_out_chroma_addr;

    // Checks
    `ASSERT_CLK(a_no_chroma_zero, i_clk, i_rst_n, o_out_valid && !o_chroma_valid |-> o_cb_value == 8'd0 && o_cr_value == 8'd0 && o_chroma_address == '0, "chroma fields not cleared")
    `ASSERT_CLK(a_luma_range, i_clk, i_rst_n, o_out_valid |-> o_luma_value >= 8'd16 && o_luma_value <= 8'd235, "luma out of range")
    `ASSERT_CLK(a_stall_blocks_in, i_clk, i_rst_n, r_s1_valid && r_out_valid && !i_out_ready |-> !o_in_ready, "input taken over a full pipeline")
    `ASSERT_CLK(a_past_end_row, i_clk, i_rst_n, r_past_end |-> r_row == CNT_W'(MAX_DIM - 1), "past-end set below last row")
    `ASSERT_CLK(a_col_bound, i_clk, i_rst_n, XY_W'(r_col) < XY_W'(MAX_DIM), "column counter beyond limit")

endmodule

@@ hw/rtl/rgb2yuv_calc.sv @@
// Color conversion and plane address arithmetic for one mapped pixel.
module rgb2yuv_calc #(
    parameter int XY_W = 14
) (
    input  rgb2yuv_pkg::t_cfg             i_cfg,
    input  logic [XY_W-1:0]               i_x,
    input  logic [XY_W-1:0]               i_y,
    input  logic [7:0]                    i_red,
    input  logic [7:0]                    i_green,
    input  logic [7:0]                    i_blue,
    output logic [7:0]                    o_luma_value,
    output logic [rgb2yuv_pkg::ADDR_W-1:0] o_luma_address,
    output logic                          o_chroma_valid,
    output logic [7:0]                    o_cb_value,
    output logic [7:0]                    o_cr_value,
    output logic [rgb2yuv_pkg::ADDR_W-1:0] o_chroma_address
);
    import rgb2yuv_pkg::*;

    localparam int PROD_W = XY_W + 13;

    logic [15:0]       y_sum;
    logic [15:0]       u_sum;
    logic [15:0]       v_sum;
    logic [PROD_W-1:0] luma_prod;
    logic [PROD_W-1:0] chroma_prod;
    logic [PROD_W-1:0] luma_sum;
    logic [PROD_W-1:0] chroma_sum;

    // Color sums; the chroma sums carry a +128<<8 bias so they never go negative
    assign y_sum = 16'(COEF_Y_R * i_red) + 16'(COEF_Y_G * i_green)
                 + 16'(COEF_Y_B * i_blue) + 16'(ROUND);
    assign u_sum = 16'(COEF_U_B * i_blue) + 16'(ROUND) + 16'(OFS_C * 256)
                 - 16'(COEF_U_R * i_red) - 16'(COEF_U_G * i_green);
    assign v_sum = 16'(COEF_V_R * i_red) + 16'(ROUND) + 16'(OFS_C * 256)
                 - 16'(COEF_V_G * i_green) - 16'(COEF_V_B * i_blue);

    // Plane addresses, wrapped to the address width
    assign luma_prod   = PROD_W'(i_y) * PROD_W'(i_cfg.luma_stride);
    assign chroma_prod = PROD_W'(i_y[XY_W-1:1]) * PROD_W'(i_cfg.chroma_stride);
    assign luma_sum    = luma_prod + PROD_W'(i_x);
    assign chroma_sum  = chroma_prod + PROD_W'(i_x[XY_W-1:1]);

    assign o_chroma_valid   = !i_x[0] && !i_y[0];
    assign o_luma_value     = y_sum[15:8] + 8'(OFS_Y);
    assign o_luma_address   = luma_sum[ADDR_W-1:0];
    assign o_cb_value       = o_chroma_valid ? u_sum[15:8] : 8'd0;
    assign o_cr_value       = o_chroma_valid ? v_sum[15:8] : 8'd0;
    assign o_chroma_address = o_chroma_valid ? chroma_sum[ADDR_W-1:0] : '0;

endmodule
